/* rtl/core/pms_pkg.sv */
// Shared types and constants for the Prim spanning tree block.
// No dependencies.
package pms_pkg;

    localparam int W_W = 22;
    localparam int V_W = 9;
    localparam int COST_W = 30;
    localparam logic [W_W-1:0] NO_EDGE = 22'h3f3f3f;

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_SOLVE = 1'b1
    } req_t;

    // wave token travelling down the cell row
    typedef struct packed
    {
        logic           tok;
        logic           found;
        logic [W_W-1:0] best;
    } wave_t;

    // broadcast to every cell
    typedef struct packed
    {
        logic           init;
        logic [V_W-1:0] n;
        logic [W_W-1:0] w;
    } cell_ctl_t;

endpackage

/* rtl/core/pms_cell.sv */
// One vertex cell: holds distance and tree flag, relaxes and passes the running minimum.
// Depends on pms_pkg.
module pms_cell #(
    parameter int VW  = 8,
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pms_pkg::cell_ctl_t ctl,
    input  logic [VW-1:0]     k,
    input  pms_pkg::wave_t    wave_in,
    input  logic [VW-1:0]     idx_in,
    output pms_pkg::wave_t    wave_out,
    output logic [VW-1:0]     idx_out
);

    logic [pms_pkg::W_W-1:0] dist_reg, dist_next;
    logic                    in_reg, in_next;
    logic                    tok_reg;
    logic                    found_reg, found_next;
    logic [pms_pkg::W_W-1:0] best_reg, best_next;
    logic [VW-1:0]           idx_reg, idx_next;
    logic                    active, in_eff, cand;

    always_comb
    begin
        active     = 32'(ctl.n) > IDX;
        in_eff     = in_reg | (k == VW'(IDX));
        dist_next  = dist_reg;
        in_next    = in_reg;
        found_next = wave_in.found;
        best_next  = wave_in.best;
        idx_next   = idx_in;
        cand       = 1'b0;
        if (ctl.init)
        begin
            dist_next = pms_pkg::NO_EDGE;
            in_next   = (IDX == 0);
        end
        else if (wave_in.tok)
        begin
            in_next = in_eff;
            if (active && !in_eff && ctl.w < dist_reg)
            begin
                dist_next = ctl.w;
            end
            cand = active && !in_eff && dist_next < wave_in.best;
            if (cand)
            begin
                found_next = 1'b1;
                best_next  = dist_next;
                idx_next   = VW'(IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= wave_in.tok & ~ctl.init;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_next;
        in_reg    <= in_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        idx_reg   <= idx_next;
    end

    assign wave_out.tok   = tok_reg;
    assign wave_out.found = found_reg;
    assign wave_out.best  = best_reg;
    assign idx_out        = idx_reg;

endmodule

/* rtl/core/prim_minimum_spanning_tree.sv */
// Top level: edge matrix memory, solve sequencer and the row of vertex cells.
// Depends on pms_pkg and pms_cell.
//
// A load with both endpoints in range passes through S_LOAD; one with an endpoint out of
// range is dropped. A solve on n vertices runs up to n-1 rounds: each round streams one
// matrix row, one entry a cycle, through the cell row and waits for the wave to leave the
// last cell. After the result, and after reset, busy stays high while the single write
// port resets the matrix to no-edge. The result strobe done lasts one cycle and cannot be
// held off.
module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [pms_pkg::V_W-1:0]     vertex_a,
    input  logic [pms_pkg::V_W-1:0]     vertex_b,
    input  logic [pms_pkg::W_W-1:0]     edge_weight,
    output logic                        done,
    output logic [pms_pkg::COST_W-1:0]  total_cost,
    output logic                        connected,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pms_pkg::V_W-1:0]     cfg_data
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             clr_reg, clr_next;
    logic [VW-1:0]             col_reg, col_next;
    logic [VW-1:0]             k_reg, k_next;
    logic [pms_pkg::V_W-1:0]   round_reg, round_next;
    logic [pms_pkg::V_W-1:0]   n_reg, n_next;
    logic [pms_pkg::V_W-1:0]   cfg_reg;
    logic [pms_pkg::COST_W-1:0] cost_reg, cost_next;
    logic                      conn_reg, conn_next;
    logic                      done_reg, done_next;
    logic                      launch_reg, launch_next;
    logic [pms_pkg::W_W-1:0]   w_reg;
    logic [AW-1:0]             la_reg;

    logic [pms_pkg::W_W-1:0]   mem [0:DEPTH-1];
    logic [pms_pkg::W_W-1:0]   rdata_reg;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic [pms_pkg::W_W-1:0]   wr_data;
    logic                      wr_en;

    logic                      accept, load_ok, init;
    logic [VW-1:0]             va, vb, ra, rb;
    logic [pms_pkg::V_W-1:0]   n_eff;

    pms_pkg::cell_ctl_t        ctl;
    pms_pkg::wave_t            wave [0:MAX_VERTICES];
    logic [VW-1:0]             widx [0:MAX_VERTICES];

    function automatic logic [AW-1:0] tri_addr(input logic [VW-1:0] r, input logic [VW-1:0] c);
        logic [AW-1:0] a;
        begin
            a = (r < c) ? {r, c} : {c, r};
            return a;
        end
    endfunction

    assign accept    = start && !busy;
    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign va        = VW'(vertex_a - 9'd1);
    assign vb        = VW'(vertex_b - 9'd1);
    assign load_ok   = vertex_a != '0 && vertex_b != '0
                       && 32'(vertex_a) <= MAX_VERTICES && 32'(vertex_b) <= MAX_VERTICES;
    assign n_eff     = (cfg_reg == '0) ? 9'd1
                       : ((32'(cfg_reg) > MAX_VERTICES) ? pms_pkg::V_W'(MAX_VERTICES) : cfg_reg);
    assign init      = accept && req_type == pms_pkg::REQ_SOLVE;

    always_comb
    begin
        ra      = (state_reg == S_ISSUE) ? k_reg : va;
        rb      = (state_reg == S_ISSUE) ? col_reg : vb;
        rd_addr = tri_addr(ra, rb);
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = pms_pkg::NO_EDGE;
        if (state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_LOAD && w_reg < rdata_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = la_reg;
            wr_data = w_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
        if (accept)
        begin
            w_reg  <= edge_weight;
            la_reg <= rd_addr;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        round_next  = round_reg;
        n_next      = n_reg;
        cost_next   = cost_reg;
        conn_next   = conn_reg;
        done_next   = 1'b0;
        launch_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == pms_pkg::REQ_LOAD)
                    begin
                        if (load_ok)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        n_next     = n_eff;
                        cost_next  = '0;
                        conn_next  = 1'b1;
                        k_next     = '0;
                        col_next   = '0;
                        round_next = 9'd1;
                        state_next = (n_eff == 9'd1) ? S_DONE : S_ISSUE;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_ISSUE:
            begin
                launch_next = col_reg == '0;
                col_next    = col_reg + 1'b1;
                if (col_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (wave[MAX_VERTICES].tok)
                begin
                    if (!wave[MAX_VERTICES].found)
                    begin
                        conn_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cost_next = cost_reg + pms_pkg::COST_W'(wave[MAX_VERTICES].best);
                        k_next    = widx[MAX_VERTICES];
                        if (round_reg == n_reg - 9'd1)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            round_next = round_reg + 9'd1;
                            col_next   = '0;
                            state_next = S_ISSUE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                clr_next   = '0;
                state_next = S_CLEAR;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            col_reg    <= '0;
            k_reg      <= '0;
            round_reg  <= '0;
            n_reg      <= 9'd1;
            cfg_reg    <= 9'd1;
            cost_reg   <= '0;
            conn_reg   <= 1'b0;
            done_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            col_reg    <= col_next;
            k_reg      <= k_next;
            round_reg  <= round_next;
            n_reg      <= n_next;
            cost_reg   <= cost_next;
            conn_reg   <= conn_next;
            done_reg   <= done_next;
            launch_reg <= launch_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    assign done       = done_reg;
    assign total_cost = cost_reg;
    assign connected  = conn_reg;

    assign ctl.init = init;
    assign ctl.n    = init ? n_eff : n_reg;
    assign ctl.w    = rdata_reg;

    assign wave[0].tok   = launch_reg;
    assign wave[0].found = 1'b0;
    assign wave[0].best  = pms_pkg::NO_EDGE;
    assign widx[0]       = '0;

    for (genvar j = 0; j < MAX_VERTICES; j++)
    begin : g_cell
        pms_cell #(
            .VW  (VW),
            .IDX (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .k        (k_reg),
            .wave_in  (wave[j]),
            .idx_in   (widx[j]),
            .wave_out (wave[j+1]),
            .idx_out  (widx[j+1])
        );
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == pms_pkg::REQ_SOLVE || load_ok)) |=> busy)
        else $error("accepted request did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_wave_end: assert property (@(posedge clk) disable iff (!rst_n)
        wave[MAX_VERTICES].tok |-> state_reg == S_WAIT)
        else $error("wave left cell row outside wait");
    a_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> round_reg < n_reg) else $error("round past vertex count");

endmodule
